>>> sv/itip_pkg.sv
// Shared types, grid constants and refractive index tables for the
// table interpolation permittivity unit. No dependencies.
package itip_pkg;

  localparam int GridStart  = 1000;
  localparam int GridStep   = 250;
  localparam int TableLen   = 21;
  localparam int Den        = 25000;
  localparam int HalfDen    = 12500;
  localparam int NumW       = 18;
  localparam int RecipShift = 18;
  localparam int WaveW      = 13;
  localparam int IdxW       = 6;
  localparam int FracW      = 8;
  localparam int TabW       = 10;
  localparam int IndexW     = 16;
  localparam int PermRealW  = 20;
  localparam int PermImagW  = 21;
  localparam int ProdW      = 32;
  localparam int WideW      = 34;

  typedef logic [TabW-1:0]  tab_t;
  typedef logic [FracW-1:0] frac_t;
  typedef logic [IdxW-1:0]  idx_t;

  localparam tab_t TabReal [TableLen] = '{
    10'd220, 10'd270, 10'd310, 10'd365, 10'd400, 10'd440, 10'd495, 10'd530, 10'd570,
    10'd600, 10'd620, 10'd650, 10'd670, 10'd703, 10'd725, 10'd762, 10'd774, 10'd796,
    10'd818, 10'd836, 10'd862
  };

  localparam tab_t TabImag [TableLen] = '{
    10'd350, 10'd430, 10'd490, 10'd540, 10'd570, 10'd610, 10'd640, 10'd670, 10'd710,
    10'd730, 10'd770, 10'd800, 10'd820, 10'd830, 10'd865, 10'd880, 10'd907, 10'd924,
    10'd946, 10'd970, 10'd985
  };

  // Entries beyond the stored table or beyond the grid length read as zero.
  function automatic tab_t rom_read(input logic is_imag, input idx_t idx,
                                    input int num_points);
    tab_t val;
    val = '0;
    if (int'(idx) < TableLen && int'(idx) < num_points) begin
      val = is_imag ? TabImag[idx[4:0]] : TabReal[idx[4:0]];
    end
    return val;
  endfunction

endpackage

>>> sv/itip_lerp.sv
// Four-stage linear interpolation with round-to-nearest scaling to Q.FRAC_BITS
// and saturation to 16 bits. Depends on itip_pkg.
module itip_lerp #(
  parameter int FRAC_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  itip_pkg::tab_t                t0_i,
  input  itip_pkg::tab_t                t1_i,
  input  itip_pkg::frac_t               r_i,
  input  itip_pkg::frac_t               w_i,
  output logic [itip_pkg::IndexW-1:0]   index_o
);
  import itip_pkg::*;

  localparam int AW = NumW + FRAC_BITS + 1;
  localparam int MW = FRAC_BITS + 4;
  localparam int PW = NumW + MW + 1;
  localparam int VW = PW - RecipShift;
  localparam logic [MW-1:0] RecipM =
    MW'((64'd1 << (FRAC_BITS + RecipShift)) / 64'd25000);

  logic [NumW-1:0]   num_d, num_q;
  logic [PW-1:0]     p_d, p_q;
  logic [AW-1:0]     a_d, a_q;
  logic [VW-1:0]     vest_d, vest_q;
  logic [AW-1:0]     rem;
  logic              ge_d, ge_q;
  logic [VW:0]       v;
  logic [IndexW-1:0] index_d, index_q;

  assign num_d = NumW'(t0_i) * NumW'(w_i) + NumW'(t1_i) * NumW'(r_i);

  assign p_d = PW'(num_q) * PW'(RecipM) + (PW'(1) << (RecipShift - 1));
  assign a_d = (AW'(num_q) << FRAC_BITS) + AW'(HalfDen);

  assign vest_d = p_q[PW-1:RecipShift];
  assign rem    = a_q - AW'(vest_d) * AW'(Den);
  assign ge_d   = rem >= AW'(Den);

  assign v       = (VW+1)'(vest_q) + (VW+1)'(ge_q);
  assign index_d = (32'(v) > 32'hFFFF) ? 16'hFFFF : 16'(v);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= num_d;
      p_q     <= p_d;
      a_q     <= a_d;
      vest_q  <= vest_d;
      ge_q    <= ge_d;
      index_q <= index_d;
    end
  end

  assign index_o = index_q;

endmodule

>>> sv/index_table_interp_permittivity_unit.sv
// Top level: complex refractive index and permittivity by table interpolation.
// Depends on itip_pkg and itip_lerp.
//
//   channel  signals                                          direction
//   in       in_valid_i, in_stall_o, wavelength_i             into block
//   out      out_valid_o, out_stall_i, in_range_o, index_*_o,  out of block
//            perm_real_o, perm_imag_o
//
// One item per cycle enters while in_stall_o is low; each result passes through
// the grid divide, table read, four interpolation stages, the squaring
// multipliers and the rounding stage. Reset clears only the valid bits.
// A stalled valid output freezes the pipeline, so nothing is lost or repeated.
module index_table_interp_permittivity_unit #(
  parameter int NUM_POINTS = 21,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [itip_pkg::WaveW-1:0]            wavelength_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  in_range_o,
  output logic [itip_pkg::IndexW-1:0]           index_real_o,
  output logic [itip_pkg::IndexW-1:0]           index_imag_o,
  output logic signed [itip_pkg::PermRealW-1:0] perm_real_o,
  output logic signed [itip_pkg::PermImagW-1:0] perm_imag_o
);
  import itip_pkg::*;

  localparam int Depth = 10;
  localparam int Last  = GridStart + GridStep * (NUM_POINTS - 1);

  logic             en;
  logic [Depth-1:0] vld_q;
  logic [Depth-1:0] rng_q;
  logic             rng_d;

  logic [WaveW-1:0]   d_d, d_q;
  logic [21:0]        qmul;
  idx_t               qe_d, qe_q;
  logic [WaveW-1:0]   r0;
  logic               ge250;
  idx_t               i_d, i_q;
  frac_t              r_d, r_q;
  tab_t               tr0_q, tr1_q, ti0_q, ti1_q;
  frac_t              fr_q, fw_q;
  logic [IndexW-1:0]  nr, ni;
  logic [IndexW-1:0]  nr8_q, ni8_q, nr9_q, ni9_q;
  logic [ProdW-1:0]   sqr_q, sqi_q, crs_q;
  logic signed [WideW-1:0] pr_q, pi_q;
  logic signed [WideW-1:0] pr_rnd, pi_rnd;
  logic signed [PermRealW-1:0] pr_sat;
  logic signed [PermImagW-1:0] pi_sat;

  logic                        rng_out_q;
  logic [IndexW-1:0]           nr_out_q, ni_out_q;
  logic signed [PermRealW-1:0] pr_out_q;
  logic signed [PermImagW-1:0] pi_out_q;

  function automatic logic signed [WideW-1:0] round_shift(input logic signed [WideW-1:0] x);
    logic [WideW-1:0] mag;
    logic [WideW-1:0] sh;
    mag = x[WideW-1] ? WideW'(-x) : WideW'(x);
    sh  = (mag + (WideW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[WideW-1] ? -$signed(sh) : $signed(sh);
  endfunction

  function automatic logic signed [WideW-1:0] sat_lim(input logic signed [WideW-1:0] x,
                                                      input int width);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = (WideW'(1) <<< (width - 1)) - WideW'(1);
    lo = -hi - WideW'(1);
    priority if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end else begin
      return x;
    end
  endfunction

  assign en         = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  assign rng_d = (32'(wavelength_i) >= 32'(GridStart)) && (32'(wavelength_i) <= 32'(Last));
  assign d_d   = wavelength_i - WaveW'(GridStart);
  assign qmul  = 22'(d_d) * 22'(262);
  assign qe_d  = qmul[21:16];

  assign r0    = d_q - WaveW'(qe_q) * WaveW'(GridStep);
  assign ge250 = r0 >= WaveW'(GridStep);
  assign i_d   = ge250 ? qe_q + idx_t'(1) : qe_q;
  assign r_d   = ge250 ? FracW'(r0 - WaveW'(GridStep)) : FracW'(r0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rng_q <= {rng_q[Depth-2:0], rng_d};
      d_q   <= d_d;
      qe_q  <= qe_d;
      i_q   <= i_d;
      r_q   <= r_d;
      tr0_q <= rom_read(1'b0, i_q, NUM_POINTS);
      tr1_q <= rom_read(1'b0, i_q + idx_t'(1), NUM_POINTS);
      ti0_q <= rom_read(1'b1, i_q, NUM_POINTS);
      ti1_q <= rom_read(1'b1, i_q + idx_t'(1), NUM_POINTS);
      fr_q  <= r_q;
      fw_q  <= FracW'(GridStep) - r_q;
    end
  end

  itip_lerp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_lerp_real (
    .clk_i  (clk_i),
    .en_i   (en),
    .t0_i   (tr0_q),
    .t1_i   (tr1_q),
    .r_i    (fr_q),
    .w_i    (fw_q),
    .index_o(nr)
  );

  itip_lerp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_lerp_imag (
    .clk_i  (clk_i),
    .en_i   (en),
    .t0_i   (ti0_q),
    .t1_i   (ti1_q),
    .r_i    (fr_q),
    .w_i    (fw_q),
    .index_o(ni)
  );

  assign pr_rnd = round_shift(pr_q);
  assign pi_rnd = round_shift(pi_q);
  assign pr_sat = PermRealW'(sat_lim(pr_rnd, PermRealW));
  assign pi_sat = PermImagW'(sat_lim(pi_rnd, PermImagW));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqr_q     <= ProdW'(nr) * ProdW'(nr);
      sqi_q     <= ProdW'(ni) * ProdW'(ni);
      crs_q     <= ProdW'(nr) * ProdW'(ni);
      nr8_q     <= nr;
      ni8_q     <= ni;
      pr_q      <= $signed({2'b00, sqr_q}) - $signed({2'b00, sqi_q});
      pi_q      <= -$signed({1'b0, crs_q, 1'b0});
      nr9_q     <= nr8_q;
      ni9_q     <= ni8_q;
      rng_out_q <= rng_q[Depth-2];
      nr_out_q  <= rng_q[Depth-2] ? nr9_q : '0;
      ni_out_q  <= rng_q[Depth-2] ? ni9_q : '0;
      pr_out_q  <= rng_q[Depth-2] ? pr_sat : '0;
      pi_out_q  <= rng_q[Depth-2] ? pi_sat : '0;
    end
  end

  assign out_valid_o  = vld_q[Depth-1];
  assign in_range_o   = rng_out_q;
  assign index_real_o = nr_out_q;
  assign index_imag_o = ni_out_q;
  assign perm_real_o  = pr_out_q;
  assign perm_imag_o  = pi_out_q;

endmodule

>>> tb/tb_index_table_interp_permittivity_unit.sv
// Testbench for index_table_interp_permittivity_unit: streams wavelengths, predicts the
// interpolated indices and permittivity of each one and checks every result in order.
// Depends on itip_pkg and the unit itself; needs no files or arguments.
`timescale 1ns / 100ps

module tb_index_table_interp_permittivity_unit;

  localparam int NumPoints  = 21;
  localparam int FracBits   = 12;
  localparam int GridBase   = 1000;
  localparam int GridPitch  = 250;
  localparam int GridTop    = GridBase + GridPitch * (NumPoints - 1);
  localparam int RandomLen  = 1850;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 30;
  localparam int WaveBits   = itip_pkg::WaveW;

  typedef struct packed {
    logic                                  in_range;
    logic [itip_pkg::IndexW-1:0]           index_real;
    logic [itip_pkg::IndexW-1:0]           index_imag;
    logic signed [itip_pkg::PermRealW-1:0] perm_real;
    logic signed [itip_pkg::PermImagW-1:0] perm_imag;
  } optics_t;

  class optics_scoreboard;
    optics_t optics_q[$];
    int      real_hundredths[21] = '{220, 270, 310, 365, 400, 440, 495, 530, 570, 600, 620,
                                     650, 670, 703, 725, 762, 774, 796, 818, 836, 862};
    int      imag_hundredths[21] = '{350, 430, 490, 540, 570, 610, 640, 670, 710, 730, 770,
                                     800, 820, 830, 865, 880, 907, 924, 946, 970, 985};
    int      mismatches;
    int      unexpected;
    int      reported;
    int      checked;
    int      in_span;

    function longint tab_entry(bit imag, int idx);
      if (idx >= 21 || idx >= NumPoints) return 0;
      return imag ? imag_hundredths[idx] : real_hundredths[idx];
    endfunction

    function longint lerp_index(bit imag, int slot, int frac);
      longint num;
      longint v;
      num = tab_entry(imag, slot) * (GridPitch - frac) + tab_entry(imag, slot + 1) * frac;
      v = (num * (longint'(1) <<< FracBits) + (GridPitch * 50)) / (GridPitch * 100);
      return (v > 65535) ? 65535 : v;
    endfunction

    function longint round_half_away(longint d);
      longint half;
      half = longint'(1) <<< (FracBits - 1);
      if (d >= 0) return (d + half) >>> FracBits;
      return -((-d + half) >>> FracBits);
    endfunction

    function longint saturate(longint v, int width);
      longint hi;
      hi = (longint'(1) <<< (width - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function optics_t predict_optics(logic [itip_pkg::WaveW-1:0] wavelength);
      optics_t p;
      int      x;
      int      slot;
      int      frac;
      longint  nr;
      longint  ni;
      longint  er;
      longint  ei;
      p = '0;
      x = int'(wavelength);
      if (x < GridBase || x > GridTop) return p;
      slot = (x - GridBase) / GridPitch;
      frac = (x - GridBase) % GridPitch;
      nr = lerp_index(1'b0, slot, frac);
      ni = lerp_index(1'b1, slot, frac);
      er = saturate(round_half_away(nr * nr - ni * ni), itip_pkg::PermRealW);
      ei = saturate(round_half_away(-2 * nr * ni), itip_pkg::PermImagW);
      p.in_range   = 1'b1;
      p.index_real = nr[15:0];
      p.index_imag = ni[15:0];
      p.perm_real  = er[itip_pkg::PermRealW-1:0];
      p.perm_imag  = ei[itip_pkg::PermImagW-1:0];
      return p;
    endfunction

    function void note_wavelength(logic [itip_pkg::WaveW-1:0] wavelength);
      optics_q.push_back(predict_optics(wavelength));
    endfunction

    function void check_optics(optics_t got);
      optics_t want;
      if (optics_q.size() == 0) begin
        unexpected++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: result with nothing expected: %p", got);
        end
        return;
      end
      want = optics_q.pop_front();
      checked++;
      if (want.in_range) in_span++;
      if (got.in_range !== want.in_range || got.index_real !== want.index_real ||
          got.index_imag !== want.index_imag || got.perm_real !== want.perm_real ||
          got.perm_imag !== want.perm_imag) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: result %0d expected rng=%0d n'=%0d n''=%0d er=%0d ei=%0d",
                   checked, want.in_range, want.index_real, want.index_imag,
                   want.perm_real, want.perm_imag);
          $display("       actual rng=%0d n'=%0d n''=%0d er=%0d ei=%0d",
                   got.in_range, got.index_real, got.index_imag,
                   got.perm_real, got.perm_imag);
        end
      end
    endfunction

    function int pending();
      return optics_q.size();
    endfunction

    function int failures();
      return mismatches + unexpected + optics_q.size();
    endfunction
  endclass

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  in_valid_i;
  logic                                  in_stall_o;
  logic [itip_pkg::WaveW-1:0]            wavelength_i;
  logic                                  out_valid_o;
  logic                                  out_stall_i = 1'b0;
  logic                                  in_range_o;
  logic [itip_pkg::IndexW-1:0]           index_real_o;
  logic [itip_pkg::IndexW-1:0]           index_imag_o;
  logic signed [itip_pkg::PermRealW-1:0] perm_real_o;
  logic signed [itip_pkg::PermImagW-1:0] perm_imag_o;

  optics_scoreboard board;
  int               cycle_count = 0;
  int               stall_clock = 0;
  int               sent_count;

  index_table_interp_permittivity_unit #(
    .NUM_POINTS(NumPoints),
    .FRAC_BITS (FracBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .wavelength_i(wavelength_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .in_range_o  (in_range_o),
    .index_real_o(index_real_o),
    .index_imag_o(index_imag_o),
    .perm_real_o (perm_real_o),
    .perm_imag_o (perm_imag_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("ERROR: run timed out after %0d cycles", cycle_count);
      $display("FAIL index_table_interp_permittivity_unit");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      board.check_optics({in_range_o, index_real_o, index_imag_o, perm_real_o, perm_imag_o});
    end
    stall_clock <= stall_clock + 1;
    case (stall_clock[9:7])
      3'd0, 3'd1: begin
        out_stall_i <= 1'b0;
      end
      3'd2, 3'd5: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      3'd3: begin
        out_stall_i <= (stall_clock[2:0] < 3'd3);
      end
      3'd4: begin
        out_stall_i <= ($urandom_range(0, 9) < 7);
      end
      default: begin
        out_stall_i <= stall_clock[4];
      end
    endcase
  end

  task automatic send_wavelength(input logic [itip_pkg::WaveW-1:0] wavelength);
    in_valid_i   <= 1'b1;
    wavelength_i <= wavelength;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.note_wavelength(wavelength);
    sent_count++;
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  function automatic logic [itip_pkg::WaveW-1:0] pick_wavelength();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) return WaveBits'($urandom_range(GridBase, GridTop));
    if (pick < 82) return WaveBits'(GridBase + GridPitch * $urandom_range(0, NumPoints - 1));
    if (pick < 88) return WaveBits'($urandom_range(GridBase - 3, GridBase + 3));
    if (pick < 93) return WaveBits'($urandom_range(GridTop - 3, GridTop + 3));
    return WaveBits'($urandom_range(0, 8191));
  endfunction

  initial begin
    logic [itip_pkg::WaveW-1:0] directed [$];
    int                         burst_left;
    int                         gap;

    board        = new();
    sent_count   = 0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    wavelength_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{13'd0, 13'd8191, 13'd999, 13'd1000, 13'd1001, 13'd1124, 13'd1249,
                 13'd1250, 13'd3500, 13'd4321, 13'd5749, 13'd5750, 13'd5999, 13'd6000,
                 13'd6001, 13'd7000, 13'd4095, 13'd4096, 13'd2047, 13'd2730, 13'd5461};
    foreach (directed[k]) begin
      send_wavelength(directed[k]);
    end
    hold_until_drained();

    burst_left = $urandom_range(1, 40);
    for (int n = 0; n < RandomLen; n++) begin
      send_wavelength(pick_wavelength());
      if (n == RandomLen / 2) begin
        hold_until_drained();
      end else if (--burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                                 : $urandom_range(1, 40);
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    hold_until_drained();
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d wavelengths, checked %0d results (%0d inside the table span).",
             sent_count, board.checked, board.in_span);
    $display("Mismatches %0d, unexpected results %0d, still pending %0d.",
             board.mismatches, board.unexpected, board.pending());
    if (board.failures() == 0) begin
      $display("PASS index_table_interp_permittivity_unit");
    end else begin
      $display("FAIL index_table_interp_permittivity_unit");
    end
    $finish;
  end

endmodule
